FILE: hw/rtl/ddk_pkg.sv
// Package for the deque delete-by-key unit: list depth, command and status codes,
// cell operation codes and the control struct shared by the top level and its cells.
// No dependencies.
`default_nettype none

package ddk_pkg;

	localparam int DEPTH = 32;
	localparam int KEY_W = 32;
	localparam int CNT_W = $clog2(DEPTH);

	localparam logic [2:0] CMD_INSERT    = 3'd0;
	localparam logic [2:0] CMD_DELETE    = 3'd1;
	localparam logic [2:0] CMD_DEL_FIRST = 3'd2;
	localparam logic [2:0] CMD_DEL_LAST  = 3'd3;
	localparam logic [2:0] CMD_READ      = 3'd4;

	localparam logic [1:0] STAT_DONE = 2'd0;
	localparam logic [1:0] STAT_MISS = 2'd1;
	localparam logic [1:0] STAT_FULL = 2'd2;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_REMOVE,
		CELL_ROTATE
	} cell_op_t;

	typedef enum logic [1:0] {
		MATCH_KEY,
		MATCH_HEAD,
		MATCH_TAIL
	} match_mode_t;

	typedef enum logic {
		ST_IDLE,
		ST_READ
	} state_t;

	typedef struct packed {
		cell_op_t           op;
		match_mode_t        mode;
		logic signed [KEY_W-1:0] del_key;
	} cell_ctrl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ddk_cell.sv
// One cell of the list chain: holds one key and its valid bit and trades them with
// its neighbors. Depends on ddk_pkg for the control struct and operation codes.
`default_nettype none

module ddk_cell (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire ddk_pkg::cell_ctrl_t              ctrl,
	input  wire logic signed [ddk_pkg::KEY_W-1:0] left_key,
	input  wire logic                             left_valid,
	input  wire logic signed [ddk_pkg::KEY_W-1:0] right_key,
	input  wire logic                             right_valid,
	input  wire logic                             seen_in,
	output logic                                  seen_out,
	output logic signed [ddk_pkg::KEY_W-1:0]      key_q,
	output logic                                  valid_q
);

	logic                             match;
	logic signed [ddk_pkg::KEY_W-1:0] key_d;
	logic                             valid_d;

	always_comb begin
		case (ctrl.mode)
			ddk_pkg::MATCH_HEAD: match = valid_q && !left_valid;
			ddk_pkg::MATCH_TAIL: match = valid_q && !right_valid;
			default:             match = valid_q && (key_q == ctrl.del_key);
		endcase
		seen_out = seen_in || match;
	end

	always_comb begin
		key_d   = key_q;
		valid_d = valid_q;
		case (ctrl.op)
			ddk_pkg::CELL_INSERT: begin
				key_d   = left_key;
				valid_d = left_valid;
			end
			ddk_pkg::CELL_REMOVE: begin
				if (seen_out) begin
					key_d   = right_key;
					valid_d = right_valid;
				end
			end
			ddk_pkg::CELL_ROTATE: begin
				key_d   = right_key;
				valid_d = right_valid;
			end
			default: begin
				key_d   = key_q;
				valid_d = valid_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		key_q <= key_d;
	end

endmodule

`default_nettype wire

FILE: hw/rtl/deque_delete_by_key_unit.sv
// Top level of the deque delete-by-key unit: command decode, read-out sequencer,
// output register and the chain of ddk_cell instances. Depends on ddk_pkg and ddk_cell.
//
// The unit keeps up to DEPTH signed keys in a row of cells, front entry in cell 0.
// Insert, delete by key, delete first and delete last each take one word and update
// all cells in the same cycle, answering with one word on the next cycle; a delete by
// key removes the first match counted from the front. Read-out takes its command word
// and then rotates the whole cell ring left one place a cycle until every cell has
// been at the front once, sending the front key out whenever the front cell is valid;
// a rotation step holds while a valid front key finds the output register still full,
// and no new command is taken until the rotation is done. Results pass through an
// output register, so a command is taken while the previous answer is being consumed.
`default_nettype none

module deque_delete_by_key_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // [31:0] key
	input  wire logic [2:0]  s_tuser,  // [2:0] cmd
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,  // [31:0] out_key
	output logic [2:0]       m_tuser,  // [0] key_valid, [2:1] status
	output logic             m_tlast
);

	localparam int DEPTH = ddk_pkg::DEPTH;

	ddk_pkg::state_t     state_q, state_d;
	ddk_pkg::cell_ctrl_t ctrl;
	logic [ddk_pkg::CNT_W-1:0] rd_cnt_q, rd_cnt_d;

	logic signed [ddk_pkg::KEY_W-1:0] cell_key [DEPTH];
	logic [DEPTH-1:0]                 valid_vec;
	logic [DEPTH:0]                   seen;
	logic                             full, found, out_free, accept, step;

	logic        out_valid_q, out_kv_q, out_last_q;
	logic [31:0] out_key_q;
	logic [1:0]  out_st_q;
	logic        load;
	logic [31:0] load_key;
	logic        load_kv, load_last;
	logic [1:0]  load_st;

	assign full     = valid_vec[DEPTH-1];
	assign found    = seen[DEPTH];
	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == ddk_pkg::ST_IDLE) && out_free;
	assign accept   = s_tvalid && s_tready;
	assign step     = !valid_vec[0] || out_free;
	assign seen[0]  = 1'b0;

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic signed [ddk_pkg::KEY_W-1:0] lkey, rkey;
			logic                             lval, rval;
			if (gi == 0) begin : g_head
				assign lkey = $signed(s_tdata);
				assign lval = (ctrl.op == ddk_pkg::CELL_INSERT);
			end else begin : g_mid_l
				assign lkey = cell_key[gi-1];
				assign lval = valid_vec[gi-1];
			end
			if (gi == DEPTH-1) begin : g_tail
				assign rkey = cell_key[0];
				assign rval = (ctrl.op == ddk_pkg::CELL_ROTATE) && valid_vec[0];
			end else begin : g_mid_r
				assign rkey = cell_key[gi+1];
				assign rval = valid_vec[gi+1];
			end
			ddk_cell u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.ctrl        (ctrl),
				.left_key    (lkey),
				.left_valid  (lval),
				.right_key   (rkey),
				.right_valid (rval),
				.seen_in     (seen[gi]),
				.seen_out    (seen[gi+1]),
				.key_q       (cell_key[gi]),
				.valid_q     (valid_vec[gi])
			);
		end
	endgenerate

	always_comb begin
		state_d      = state_q;
		rd_cnt_d     = rd_cnt_q;
		ctrl.op      = ddk_pkg::CELL_HOLD;
		ctrl.mode    = ddk_pkg::MATCH_KEY;
		ctrl.del_key = $signed(s_tdata);
		load         = 1'b0;
		load_key     = '0;
		load_kv      = 1'b0;
		load_st      = ddk_pkg::STAT_DONE;
		load_last    = 1'b1;
		case (state_q)
			ddk_pkg::ST_IDLE: begin
				if (accept) begin
					load = 1'b1;
					case (s_tuser)
						ddk_pkg::CMD_INSERT: begin
							if (full) begin
								load_st = ddk_pkg::STAT_FULL;
							end else begin
								ctrl.op = ddk_pkg::CELL_INSERT;
							end
						end
						ddk_pkg::CMD_DELETE: begin
							ctrl.op = ddk_pkg::CELL_REMOVE;
							load_st = found ? ddk_pkg::STAT_DONE : ddk_pkg::STAT_MISS;
						end
						ddk_pkg::CMD_DEL_FIRST: begin
							ctrl.op   = ddk_pkg::CELL_REMOVE;
							ctrl.mode = ddk_pkg::MATCH_HEAD;
							load_st   = found ? ddk_pkg::STAT_DONE : ddk_pkg::STAT_MISS;
						end
						ddk_pkg::CMD_DEL_LAST: begin
							ctrl.op   = ddk_pkg::CELL_REMOVE;
							ctrl.mode = ddk_pkg::MATCH_TAIL;
							load_st   = found ? ddk_pkg::STAT_DONE : ddk_pkg::STAT_MISS;
						end
						ddk_pkg::CMD_READ: begin
							if (valid_vec[0]) begin
								load     = 1'b0;
								state_d  = ddk_pkg::ST_READ;
								rd_cnt_d = '0;
							end else begin
								load_st = ddk_pkg::STAT_MISS;
							end
						end
						default: begin
							load_st = ddk_pkg::STAT_DONE;
						end
					endcase
				end
			end
			ddk_pkg::ST_READ: begin
				if (step) begin
					ctrl.op   = ddk_pkg::CELL_ROTATE;
					load      = valid_vec[0];
					load_key  = cell_key[0];
					load_kv   = 1'b1;
					load_last = !valid_vec[1] ||
						(rd_cnt_q == ddk_pkg::CNT_W'(DEPTH - 1));
					rd_cnt_d  = rd_cnt_q + 1'b1;
					if (rd_cnt_q == ddk_pkg::CNT_W'(DEPTH - 1)) begin
						state_d = ddk_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ddk_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ddk_pkg::ST_IDLE;
			rd_cnt_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			rd_cnt_q <= rd_cnt_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_key_q  <= load_key;
			out_kv_q   <= load_kv;
			out_st_q   <= load_st;
			out_last_q <= load_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_key_q;
	assign m_tuser  = {out_st_q, out_kv_q};
	assign m_tlast  = out_last_q;

	a_no_accept_in_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ddk_pkg::ST_READ) |-> !s_tready)
		else $error("Input word taken during read-out.");

	a_prefix_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ddk_pkg::ST_IDLE) |-> ((valid_vec & (valid_vec + 1'b1)) == '0))
		else $error("Occupied cells do not form a prefix.");

	a_insert_front: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (s_tuser == ddk_pkg::CMD_INSERT) && !full) |=>
		(valid_vec[0] && (cell_key[0] == $past($signed(s_tdata)))))
		else $error("Inserted key missing from the front cell.");

	a_key_status: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tuser[2:1] == ddk_pkg::STAT_DONE))
		else $error("Read-out word carries a failure status.");

endmodule

`default_nettype wire
